@@ rtl/sliding_window_mean_median_unit_assert.svh @@
// Assertion macros for the sliding-window mean/median unit.
// Included by the top level; no other dependencies.
`ifndef SLIDING_WINDOW_MEAN_MEDIAN_UNIT_ASSERT_SVH
`define SLIDING_WINDOW_MEAN_MEDIAN_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SWMM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("swmm assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define SWMM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("swmm assertion failed");

`endif

@@ rtl/swmm_pkg.sv @@
// Shared types and constants for the sliding-window mean/median unit.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package swmm_pkg;

  localparam int SAMPLE_W = 8;

  // Item kind codes
  localparam logic KIND_ADD = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COUNT,
    ST_SCAN,
    ST_DIV
  } state_e;

  // Per-cycle commands broadcast to every cell of the chain
  typedef struct packed {
    logic shift;   // shift the window one place toward the oldest end
    logic load;    // load each token from the cell's updated sample
    logic count;   // advance tokens and accumulate rank counts
    logic rotate;  // advance tokens without counting
  } cell_ctrl_t;

endpackage

@@ rtl/swmm_if.sv @@
// Valid/ready channel interfaces for items and results.
// Depends on swmm_pkg.
`timescale 1ns / 1ps

interface swmm_in_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [swmm_pkg::SAMPLE_W-1:0] sample_value;

  modport source (output valid, output kind, output sample_value, input ready);
  modport sink   (input valid, input kind, input sample_value, output ready);
endinterface

interface swmm_out_if;
  logic                          valid;
  logic                          ready;
  logic [swmm_pkg::SAMPLE_W-1:0] window_mean;
  logic [swmm_pkg::SAMPLE_W-1:0] window_median;
  logic                          value_present;

  modport source (output valid, output window_mean, output window_median,
                  output value_present, input ready);
  modport sink   (input valid, input window_mean, input window_median,
                  input value_present, output ready);
endinterface

@@ rtl/sliding_window_mean_median_unit.sv @@
// Sliding-window mean/median unit: top level.
// Depends on swmm_pkg, swmm_if, swmm_cell, swmm_mean_div and the assert header.
//
// in_i  (sink)   : one item per transfer; kind selects add (shift sample_value
//                  into the window, drop the oldest) or query (keep the window).
// out_o (source) : one result per item: floor mean, median (sorted index
//                  WINDOW/2, upper median for even WINDOW) and whether
//                  sample_value occurs in the window after the step.
// The window is a chain of WINDOW cells, oldest sample in cell 0. Each cell also
// holds a rank token; tokens circulate the ring once collecting less-than and
// less-or-equal counts, then once more past cell 0, where sum, presence and
// median are picked up. A reciprocal multiply in the divider then turns the sum
// into the mean.
// An item goes through ST_COUNT, ST_SCAN and ST_DIV before out_o.valid rises.
// The two ring passes and the divider handle one item at a time;
// in_i.ready is high only while no item is in flight.
// A finished result waits in the output register, so the next item is taken
// while it waits; if out_o still stalls when that next result is done, hold
// it in the divider and keep in_i.ready low until the register frees up.
// Reset (rst_ni low, asynchronous) clears the window, the output valid flag and control.
`timescale 1ns / 1ps
`include "sliding_window_mean_median_unit_assert.svh"

module sliding_window_mean_median_unit #(
  parameter int WINDOW = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  swmm_in_if.sink             in_i,
  swmm_out_if.source          out_o
);

  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = $clog2(WINDOW * 255 + 1);
  localparam int STEP_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int MED_K  = WINDOW / 2;

  // ---------------------------------------------------------------- control
  swmm_pkg::state_e     state_q, state_d;
  logic [STEP_W-1:0]    step_q, step_d;
  logic                 step_last;
  logic                 in_xfer;
  logic                 out_free;
  logic                 out_load;
  logic                 div_start;
  logic                 div_valid;
  swmm_pkg::cell_ctrl_t ctrl;

  // ---------------------------------------------------------------- datapath
  logic [swmm_pkg::SAMPLE_W-1:0] sample_w  [WINDOW];
  logic [swmm_pkg::SAMPLE_W-1:0] tok_val_w [WINDOW];
  logic [CNT_W-1:0]              tok_lt_w  [WINDOW];
  logic [CNT_W-1:0]              tok_le_w  [WINDOW];

  logic [swmm_pkg::SAMPLE_W-1:0] query_q;
  logic                          kind_q;
  logic [SUM_W-1:0]              sum_q, sum_d;
  logic                          pres_q, pres_d;
  logic [swmm_pkg::SAMPLE_W-1:0] med_q, med_d;
  logic                          med_hit;
  logic [swmm_pkg::SAMPLE_W-1:0] mean;

  logic                          out_valid_q;
  logic [swmm_pkg::SAMPLE_W-1:0] out_mean_q, out_median_q;
  logic                          out_present_q;

  assign in_xfer   = in_i.valid && in_i.ready;
  assign step_last = (step_q == STEP_W'(WINDOW - 1));
  assign out_free  = !out_valid_q || out_o.ready;

  // Next state and step counter
  always_comb begin
    state_d = state_q;
    step_d  = '0;
    case (state_q)
      swmm_pkg::ST_IDLE: begin
        if (in_xfer) state_d = swmm_pkg::ST_COUNT;
      end
      swmm_pkg::ST_COUNT: begin
        step_d = step_last ? '0 : step_q + 1'b1;
        if (step_last) state_d = swmm_pkg::ST_SCAN;
      end
      swmm_pkg::ST_SCAN: begin
        step_d = step_last ? '0 : step_q + 1'b1;
        if (step_last) state_d = swmm_pkg::ST_DIV;
      end
      swmm_pkg::ST_DIV: begin
        if (div_valid && out_free) state_d = swmm_pkg::ST_IDLE;
      end
      default: state_d = swmm_pkg::ST_IDLE;
    endcase
  end

  // Control outputs; ready is high throughout idle, so valid alone marks a transfer
  always_comb begin
    ctrl       = '0;
    in_i.ready = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      swmm_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        ctrl.load  = in_i.valid;
        ctrl.shift = in_i.valid && (in_i.kind == swmm_pkg::KIND_ADD);
      end
      swmm_pkg::ST_COUNT: ctrl.count = 1'b1;
      swmm_pkg::ST_SCAN: begin
        ctrl.rotate = 1'b1;
        div_start   = step_last;
      end
      swmm_pkg::ST_DIV: out_load = div_valid && out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= swmm_pkg::ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Cell chain: samples shift toward cell 0, tokens advance from cell i to i+1
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    localparam int PREV = (i + WINDOW - 1) % WINDOW;
    logic [swmm_pkg::SAMPLE_W-1:0] shift_val;

    if (i == WINDOW - 1) begin : g_newest
      assign shift_val = in_i.sample_value;
    end else begin : g_inner
      assign shift_val = sample_w[i + 1];
    end

    swmm_cell #(
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .shift_val_i (shift_val),
      .sample_o    (sample_w[i]),
      .tok_val_i   (tok_val_w[PREV]),
      .tok_lt_i    (tok_lt_w[PREV]),
      .tok_le_i    (tok_le_w[PREV]),
      .tok_val_o   (tok_val_w[i]),
      .tok_lt_o    (tok_lt_w[i]),
      .tok_le_o    (tok_le_w[i])
    );
  end

  // A token whose value has rank MED_K: fewer than or equal MED_K below it,
  // more than MED_K at or below it. Duplicates all carry the same value.
  assign med_hit = (tok_lt_w[0] <= CNT_W'(MED_K)) && (tok_le_w[0] > CNT_W'(MED_K));

  // Pick up sum, presence and median as tokens pass cell 0
  always_comb begin
    sum_d  = sum_q;
    pres_d = pres_q;
    med_d  = med_q;
    if (in_xfer) begin
      sum_d  = '0;
      pres_d = 1'b0;
    end else if (ctrl.rotate) begin
      sum_d  = sum_q + SUM_W'(tok_val_w[0]);
      pres_d = pres_q || (tok_val_w[0] == query_q);
      if (med_hit) med_d = tok_val_w[0];
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q  <= sum_d;
    pres_q <= pres_d;
    med_q  <= med_d;
    if (in_xfer) begin
      query_q <= in_i.sample_value;
      kind_q  <= in_i.kind;
    end
  end

  swmm_mean_div #(
    .W     (WINDOW),
    .SUM_W (SUM_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_d),
    .valid_o    (div_valid),
    .quotient_o (mean)
  );

  // Output register: load a finished result, drop it on the output transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_mean_q    <= mean;
      out_median_q  <= med_q;
      out_present_q <= pres_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.window_mean   = out_mean_q;
  assign out_o.window_median = out_median_q;
  assign out_o.value_present = out_present_q;

  // ---------------------------------------------------------------- checks
  `SWMM_ASSERT_NXT(a_accept_starts_count, clk_i, rst_ni, in_xfer,
                   (state_q == swmm_pkg::ST_COUNT) && (step_q == '0))
  `SWMM_ASSERT_IMP(a_result_from_div, clk_i, rst_ni, $rose(out_valid_q),
                   $past(state_q == swmm_pkg::ST_DIV) && $past(div_valid))
  `SWMM_ASSERT_IMP(a_add_always_present, clk_i, rst_ni,
                   out_load && (kind_q == swmm_pkg::KIND_ADD), pres_q)

endmodule

@@ rtl/swmm_cell.sv @@
// One cell of the window chain: holds one sample and one circulating rank token.
// Depends on swmm_pkg.
`timescale 1ns / 1ps

module swmm_cell #(
  parameter int CNT_W = 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  swmm_pkg::cell_ctrl_t          ctrl_i,
  input  logic [swmm_pkg::SAMPLE_W-1:0] shift_val_i,
  output logic [swmm_pkg::SAMPLE_W-1:0] sample_o,
  input  logic [swmm_pkg::SAMPLE_W-1:0] tok_val_i,
  input  logic [CNT_W-1:0]              tok_lt_i,
  input  logic [CNT_W-1:0]              tok_le_i,
  output logic [swmm_pkg::SAMPLE_W-1:0] tok_val_o,
  output logic [CNT_W-1:0]              tok_lt_o,
  output logic [CNT_W-1:0]              tok_le_o
);

  logic [swmm_pkg::SAMPLE_W-1:0] sample_q, sample_d;
  logic [swmm_pkg::SAMPLE_W-1:0] tok_val_q, tok_val_d;
  logic [CNT_W-1:0]              tok_lt_q, tok_lt_d;
  logic [CNT_W-1:0]              tok_le_q, tok_le_d;

  always_comb begin
    sample_d  = ctrl_i.shift ? shift_val_i : sample_q;
    tok_val_d = tok_val_q;
    tok_lt_d  = tok_lt_q;
    tok_le_d  = tok_le_q;
    if (ctrl_i.load) begin
      tok_val_d = sample_d;
      tok_lt_d  = '0;
      tok_le_d  = '0;
    end else if (ctrl_i.count) begin
      // rank the passing token against this cell's sample
      tok_val_d = tok_val_i;
      tok_lt_d  = tok_lt_i + CNT_W'(sample_q < tok_val_i);
      tok_le_d  = tok_le_i + CNT_W'(sample_q <= tok_val_i);
    end else if (ctrl_i.rotate) begin
      tok_val_d = tok_val_i;
      tok_lt_d  = tok_lt_i;
      tok_le_d  = tok_le_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
    end else begin
      sample_q <= sample_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_val_q <= tok_val_d;
    tok_lt_q  <= tok_lt_d;
    tok_le_q  <= tok_le_d;
  end

  assign sample_o  = sample_q;
  assign tok_val_o = tok_val_q;
  assign tok_lt_o  = tok_lt_q;
  assign tok_le_o  = tok_le_q;

endmodule

@@ rtl/swmm_mean_div.sv @@
// Mean divider: window sum divided by the window length by reciprocal multiply.
// Depends on swmm_pkg; the quotient is ready in the cycle after start.
`timescale 1ns / 1ps

module swmm_mean_div #(
  parameter int W     = 5,
  parameter int SUM_W = $clog2(W * 255 + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [SUM_W-1:0]              dividend_i,
  output logic                          valid_o,
  output logic [swmm_pkg::SAMPLE_W-1:0] quotient_o
);

  // floor(x / W) equals (x * RECIP) >> SHIFT for every x below 2**SUM_W
  localparam int LOG_W   = $clog2(W);
  localparam int SHIFT   = SUM_W + LOG_W;
  localparam int RECIP   = ((2 ** SHIFT) + W - 1) / W;
  localparam int RECIP_W = SUM_W + 2;
  localparam int PROD_W  = SUM_W + RECIP_W;

  logic [PROD_W-1:0] prod_q, prod_d;
  logic              valid_q, valid_d;

  always_comb begin
    prod_d  = prod_q;
    valid_d = valid_q;
    if (start_i) begin
      prod_d  = {{RECIP_W{1'b0}}, dividend_i} * {{SUM_W{1'b0}}, RECIP_W'(RECIP)};
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // hold the quotient until the next start
  assign valid_o    = valid_q;
  assign quotient_o = prod_q[SHIFT +: swmm_pkg::SAMPLE_W];

endmodule

@@ tb/sv/sliding_window_mean_median_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the sliding-window mean/median unit.
// Depends on swmm_pkg, swmm_if and the sliding_window_mean_median_unit RTL.

module sliding_window_mean_median_unit_tb;

  localparam int WINDOW     = 5;
  localparam int MID_RANK   = WINDOW / 2;
  localparam int LATENCY    = 2 * WINDOW + 1;
  localparam int LONG_HOLD  = 400;
  localparam int CYCLE_CAP  = 400_000;
  localparam int N_DIRECTED = 22;
  localparam int N_RAND_A   = 500;
  localparam int N_RAND_B   = 480;
  localparam int N_QUIET    = 150;
  localparam int EXP_DEPTH  = 64;

  // Only the add code lives in the package; a query is the other value.
  localparam logic KIND_QUERY = ~swmm_pkg::KIND_ADD;

  typedef struct packed {
    logic [swmm_pkg::SAMPLE_W-1:0] mean;
    logic [swmm_pkg::SAMPLE_W-1:0] median;
    logic                          present;
  } window_stats_t;

  typedef struct packed {
    logic                          kind;
    logic [swmm_pkg::SAMPLE_W-1:0] value;
    bit                            typed;
    window_stats_t                 want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  swmm_in_if  in_bus ();
  swmm_out_if out_bus ();

  sliding_window_mean_median_unit #(
    .WINDOW(WINDOW)
  ) u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_bus.sink),
    .out_o (out_bus.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted window contents, oldest sample at index 0.
  logic [swmm_pkg::SAMPLE_W-1:0] win_q [WINDOW];
  // Expected results in transfer order; the sender advances the write count,
  // the checker the read count.
  window_stats_t                 exp_mem [EXP_DEPTH];
  int                            exp_wr_cnt   = 0;
  int                            exp_rd_cnt   = 0;
  int                            mismatch_cnt = 0;
  int                            cycle_cnt    = 0;
  bit                            hold_req     = 1'b0;  // ask the result side for a long stall
  bit                            quiet        = 1'b0;  // no idling on either side

  // Directed rows. Typed expectations hold only where the window is trivial:
  // right after reset, all-zero or all-max windows and their edges.
  stim_row_t dir_rows [N_DIRECTED] = '{
    '{KIND_QUERY,          8'd0,   1'b1, '{8'd0,   8'd0,   1'b1}},
    '{KIND_QUERY,          8'd255, 1'b1, '{8'd0,   8'd0,   1'b0}},
    '{swmm_pkg::KIND_ADD,  8'd255, 1'b1, '{8'd51,  8'd0,   1'b1}},
    '{swmm_pkg::KIND_ADD,  8'd255, 1'b1, '{8'd102, 8'd0,   1'b1}},
    '{swmm_pkg::KIND_ADD,  8'd255, 1'b1, '{8'd153, 8'd255, 1'b1}},
    '{swmm_pkg::KIND_ADD,  8'd255, 1'b1, '{8'd204, 8'd255, 1'b1}},
    '{swmm_pkg::KIND_ADD,  8'd255, 1'b1, '{8'd255, 8'd255, 1'b1}},
    '{KIND_QUERY,          8'd0,   1'b1, '{8'd255, 8'd255, 1'b0}},
    '{KIND_QUERY,          8'd255, 1'b1, '{8'd255, 8'd255, 1'b1}},
    '{swmm_pkg::KIND_ADD,  8'd0,   1'b1, '{8'd204, 8'd255, 1'b1}},
    '{swmm_pkg::KIND_ADD,  8'd1,   1'b0, '0},
    '{swmm_pkg::KIND_ADD,  8'd128, 1'b0, '0},
    '{swmm_pkg::KIND_ADD,  8'd127, 1'b0, '0},
    '{KIND_QUERY,          8'd1,   1'b0, '0},
    '{KIND_QUERY,          8'd200, 1'b0, '0},
    '{swmm_pkg::KIND_ADD,  8'd128, 1'b0, '0},
    '{swmm_pkg::KIND_ADD,  8'd128, 1'b0, '0},
    '{KIND_QUERY,          8'd128, 1'b0, '0},
    '{swmm_pkg::KIND_ADD,  8'h55,  1'b0, '0},
    '{swmm_pkg::KIND_ADD,  8'hAA,  1'b0, '0},
    '{KIND_QUERY,          8'h55,  1'b0, '0},
    '{KIND_QUERY,          8'd254, 1'b0, '0}
  };

  // Advance the predicted window by one item and return the stats it yields.
  // The median is the element whose rank range covers MID_RANK: at most
  // MID_RANK elements below it, more than MID_RANK at or below it.
  function automatic window_stats_t window_stats_after(
      logic kind, logic [swmm_pkg::SAMPLE_W-1:0] value);
    window_stats_t res;
    int            sum;
    int            below;
    int            at_or_below;
    sum = 0;
    res = '0;
    if (kind == swmm_pkg::KIND_ADD) begin
      for (int i = 0; i < WINDOW - 1; i++) win_q[i] = win_q[i + 1];
      win_q[WINDOW - 1] = value;
    end
    for (int i = 0; i < WINDOW; i++) begin
      sum += win_q[i];
      if (win_q[i] == value) res.present = 1'b1;
      below       = 0;
      at_or_below = 0;
      for (int j = 0; j < WINDOW; j++) begin
        if (win_q[j] < win_q[i])  below++;
        if (win_q[j] <= win_q[i]) at_or_below++;
      end
      if (below <= MID_RANK && MID_RANK < at_or_below) res.median = win_q[i];
    end
    res.mean = swmm_pkg::SAMPLE_W'(sum / WINDOW);
    return res;
  endfunction

  // Bias values toward extremes, tight clusters (duplicates matter for the
  // median) and, for queries, values already held so presence is exercised.
  function automatic logic [swmm_pkg::SAMPLE_W-1:0] pick_sample(logic kind);
    logic [swmm_pkg::SAMPLE_W-1:0] edges [6];
    int                            mode;
    edges = '{8'd0, 8'd255, 8'd1, 8'd254, 8'd128, 8'd127};
    mode  = $urandom_range(0, 9);
    if (mode < 4) return swmm_pkg::SAMPLE_W'($urandom);
    if (mode < 6) return edges[$urandom_range(0, 5)];
    if (mode < 8 || kind == swmm_pkg::KIND_ADD)
      return swmm_pkg::SAMPLE_W'(8'd60 + $urandom_range(0, 3));
    return win_q[$urandom_range(0, WINDOW - 1)];
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    $display("ERROR at %0t: %s: got %0d, want %0d", $time, what, got, want);
    mismatch_cnt++;
  endtask

  // Offer one item and hold it until the transfer. Return on the accepting
  // edge without touching valid, so a following item keeps it high.
  task automatic send_item(logic kind, logic [swmm_pkg::SAMPLE_W-1:0] value, bit typed,
                           window_stats_t want);
    window_stats_t predicted;
    in_bus.valid        <= 1'b1;
    in_bus.kind         <= kind;
    in_bus.sample_value <= value;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    predicted = window_stats_after(kind, value);
    exp_mem[exp_wr_cnt % EXP_DEPTH] = typed ? want : predicted;
    exp_wr_cnt++;
  endtask

  // Drop valid for a random burst now and then, unless the run is quiet.
  task automatic maybe_pause_sender();
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic send_random(int count);
    logic kind;
    for (int n = 0; n < count; n++) begin
      kind = ($urandom_range(0, 9) < 6) ? swmm_pkg::KIND_ADD : KIND_QUERY;
      send_item(kind, pick_sample(kind), 1'b0, '0);
      maybe_pause_sender();
    end
  endtask

  // Main sequence: reset, directed rows, random traffic, quiet tail, verdict.
  initial begin
    rst_n               <= 1'b0;
    in_bus.valid        <= 1'b0;
    in_bus.kind         <= swmm_pkg::KIND_ADD;
    in_bus.sample_value <= '0;
    for (int i = 0; i < WINDOW; i++) win_q[i] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < N_DIRECTED; r++) begin
      send_item(dir_rows[r].kind, dir_rows[r].value, dir_rows[r].typed, dir_rows[r].want);
      maybe_pause_sender();
    end

    // Start a long result-side stall and keep offering items into it, so
    // the output register fills and the block holds off further transfers.
    send_random(N_RAND_A / 2);
    hold_req = 1'b1;
    send_random(N_RAND_A / 2);

    // Hold the input until every outstanding result has drained.
    in_bus.valid <= 1'b0;
    while (exp_wr_cnt != exp_rd_cnt) @(posedge clk);
    @(posedge clk);

    send_random(N_RAND_B);
    quiet = 1'b1;
    send_random(N_QUIET);

    in_bus.valid <= 1'b0;
    while (exp_wr_cnt != exp_rd_cnt) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);

    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Result side: random stall bursts, stretches of steady ready, and one
  // long hold-off counted here when requested.
  initial begin : drive_result_ready
    int hold_cycles;
    out_bus.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_bus.ready <= 1'b0;
        hold_cycles = 0;
        while (hold_cycles < LONG_HOLD) begin
          @(posedge clk);
          hold_cycles++;
        end
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_bus.ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  // Check every result transfer against the oldest pending expectation.
  always @(posedge clk) begin : check_results
    window_stats_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (exp_wr_cnt == exp_rd_cnt) begin
        flag_mismatch("result with nothing pending", int'(out_bus.window_mean), 0);
      end else begin
        want = exp_mem[exp_rd_cnt % EXP_DEPTH];
        exp_rd_cnt++;
        if (out_bus.window_mean !== want.mean)
          flag_mismatch("window_mean", int'(out_bus.window_mean), int'(want.mean));
        if (out_bus.window_median !== want.median)
          flag_mismatch("window_median", int'(out_bus.window_median), int'(want.median));
        if (out_bus.value_present !== want.present)
          flag_mismatch("value_present", int'(out_bus.value_present), int'(want.present));
      end
    end
  end

  // Watchdog: end the run if it outlives any plausible correct schedule.
  initial begin
    while (cycle_cnt < CYCLE_CAP) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
